### design/tcaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaf_pkg
// shared constants, codes and command type for the tet cell assembly block
// ----------------------------------------------------------------------------
package tcaf_pkg;

   // sizes of the stores and vertex width
   localparam int CELL_COUNT   = 4096;
   localparam int MARKER_COUNT = 128;
   localparam int VERTEX_BITS  = 20;

   // field widths fixed by the stream format
   localparam int KIND_W   = 2;
   localparam int VERT_W   = 20;
   localparam int LEFT_W   = 13;
   localparam int RIGHT_W  = 14;
   localparam int INDEX_W  = 12;
   localparam int FILL_W   = 2;
   localparam int COUNT_W  = 14;
   localparam int STATUS_W = 2;

   localparam int REQ_W = 104;
   localparam int RSP_W = 104;

   localparam int CORNERS_W = 4 * VERT_W;

   localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int MARK_AW = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;

   // clearing sweep covers both the fill table and the marker table
   localparam int CLR_COUNT = (CELL_COUNT > MARKER_COUNT) ? CELL_COUNT : MARKER_COUNT;
   localparam int CLR_AW    = (CLR_COUNT > 1) ? $clog2(CLR_COUNT) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   localparam logic [VERT_W-1:0] VERT_MASK = VERT_W'((64'd1 << VERTEX_BITS) - 64'd1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // item kinds
   localparam logic [KIND_W-1:0] KIND_FACE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RDCELL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RDMARK  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOFOURTH = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

   // back end operations
   typedef logic [1:0] op_type;
   localparam op_type OP_FACE   = 2'd0;
   localparam op_type OP_RDCELL = 2'd1;
   localparam op_type OP_RDMARK = 2'd2;

   typedef struct packed {
      op_type               op;
      logic                 do_left;
      logic                 do_right;
      logic                 do_mark;
      logic                 range_err;
      logic [CELL_AW-1:0]   addr_a;
      logic [CELL_AW-1:0]   addr_b;
      logic [MARK_AW-1:0]   mark_addr;
      logic [VERT_W-1:0]    va;
      logic [VERT_W-1:0]    vb;
      logic [VERT_W-1:0]    vc;
   } cmd_type;

endpackage

### design/tcaf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tcaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tcaf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaf_front
// input handshake, field decode, range checks and command build
// ----------------------------------------------------------------------------
module tcaf_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tcaf_pkg::REQ_W-1:0]    req_tdata,
   input  logic [tcaf_pkg::KIND_W-1:0]   req_tuser,
   input  logic                          clearing,
   input  logic                          q_full,
   output logic                          push,
   output tcaf_pkg::cmd_type             cmd
);

   import tcaf_pkg::*;

   logic [VERT_W-1:0]  va;
   logic [VERT_W-1:0]  vb;
   logic [VERT_W-1:0]  vc;
   logic [LEFT_W-1:0]  left;
   logic [RIGHT_W-1:0] right;
   logic [RIGHT_W-1:0] mag;
   logic [INDEX_W-1:0] ridx;
   logic               left_ok;
   logic               right_pos;
   logic               right_neg;
   logic               right_ok;
   logic               mark_ok;
   logic               rcell_ok;
   logic               rmark_ok;

   assign va    = req_tdata[19:0] & VERT_MASK;
   assign vb    = req_tdata[39:20] & VERT_MASK;
   assign vc    = req_tdata[59:40] & VERT_MASK;
   assign left  = req_tdata[72:60];
   assign right = req_tdata[86:73];
   assign ridx  = req_tdata[98:87];

   // marker number is the magnitude of a negative right entry
   assign mag       = RIGHT_W'({RIGHT_W{1'b0}} - right);
   assign left_ok   = (left != '0) && (32'(left) <= CELL_COUNT);
   assign right_neg = right[RIGHT_W-1];
   assign right_pos = !right[RIGHT_W-1] && (right != '0);
   assign right_ok  = 32'(right) <= CELL_COUNT;
   assign mark_ok   = 32'(mag) < MARKER_COUNT;
   assign rcell_ok  = 32'(ridx) < CELL_COUNT;
   assign rmark_ok  = 32'(ridx) < MARKER_COUNT;

   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      cmd           = '0;
      cmd.va        = va;
      cmd.vb        = vb;
      cmd.vc        = vc;
      cmd.addr_b    = CELL_AW'(32'(right) - 32'd1);
      case (req_tuser)
         KIND_FACE: begin
            cmd.op        = OP_FACE;
            cmd.do_left   = left_ok;
            cmd.do_right  = right_pos && right_ok;
            cmd.do_mark   = right_neg && mark_ok;
            cmd.range_err = !left_ok || (right_pos && !right_ok) || (right_neg && !mark_ok);
            cmd.addr_a    = CELL_AW'(32'(left) - 32'd1);
            cmd.mark_addr = MARK_AW'(32'(mag));
         end
         KIND_RDCELL: begin
            // a bad read becomes an empty face command that reports range
            cmd.op        = rcell_ok ? OP_RDCELL : OP_FACE;
            cmd.range_err = !rcell_ok;
            cmd.addr_a    = CELL_AW'(32'(ridx));
         end
         KIND_RDMARK: begin
            cmd.op        = rmark_ok ? OP_RDMARK : OP_FACE;
            cmd.range_err = !rmark_ok;
            cmd.mark_addr = MARK_AW'(32'(ridx));
         end
         default: begin
            cmd.op        = OP_FACE;
            cmd.range_err = 1'b1;
         end
      endcase
   end

endmodule

### design/tcaf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaf_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module tcaf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcaf_pkg::cmd_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output tcaf_pkg::cmd_type   head
);

   import tcaf_pkg::*;

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff;
   logic [QUEUE_CW-1:0]   count_in;

   assign full  = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QUEUE_CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("queue count above depth");

endmodule

### design/tcaf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcaf_back
// cell and marker table sequencer with result register
// ----------------------------------------------------------------------------
module tcaf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tcaf_pkg::cmd_type             q_head,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tcaf_pkg::RSP_W-1:0]    rsp_tdata
);

   import tcaf_pkg::*;

   localparam int PAD_W = RSP_W - (CORNERS_W + FILL_W + COUNT_W + STATUS_W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_P1   = 3'd1;
   localparam logic [2:0] S_RD2  = 3'd2;
   localparam logic [2:0] S_WR2  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
   localparam logic [FILL_W-1:0] FILL_TRI   = 2'd1;
   localparam logic [FILL_W-1:0] FILL_FULL  = 2'd2;

   logic [2:0]             state_ff;
   logic [2:0]             state_in;
   cmd_type                cmd_ff;
   cmd_type                cmd_in;
   logic [STATUS_W-1:0]    st_ff;
   logic [STATUS_W-1:0]    st_in;
   logic                   clr_ff;
   logic                   clr_in;
   logic [CLR_AW-1:0]      clr_cnt_ff;
   logic [CLR_AW-1:0]      clr_cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_W-1:0]       rsp_tdata_ff;
   logic                   rsp_load;
   logic [RSP_W-1:0]       load_data;
   logic                   out_free;

   logic [CELL_AW-1:0]     cell_ra;
   logic [CELL_AW-1:0]     cell_wa;
   logic                   cell_we;
   logic [CORNERS_W-1:0]   corner_rd;
   logic [FILL_W-1:0]      fill_rd;
   logic                   fill_we;
   logic [CELL_AW-1:0]     fill_wa;
   logic [FILL_W-1:0]      fill_wd;
   logic [MARK_AW-1:0]     mark_ra;
   logic [MARK_AW-1:0]     mark_wa;
   logic                   mark_we;
   logic [COUNT_W-1:0]     mark_wd;
   logic [COUNT_W-1:0]     mark_rd;

   logic [VERT_W-1:0]      rc0;
   logic [VERT_W-1:0]      rc1;
   logic [VERT_W-1:0]      rc2;
   logic [VERT_W-1:0]      rc3;
   logic                   fresh0;
   logic                   fresh1;
   logic                   fresh2;
   logic                   reversed;
   logic [CORNERS_W-1:0]   ab_corners;
   logic [FILL_W-1:0]      ab_fill;
   logic                   ab_we;
   logic [STATUS_W-1:0]    ab_st;
   logic                   face_p1;

   function automatic logic [STATUS_W-1:0] worse(input logic [STATUS_W-1:0] a,
                                                 input logic [STATUS_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   assign rc0 = corner_rd[VERT_W-1:0];
   assign rc1 = corner_rd[2*VERT_W-1:VERT_W];
   assign rc2 = corner_rd[3*VERT_W-1:2*VERT_W];
   assign rc3 = corner_rd[4*VERT_W-1:3*VERT_W];

   assign fresh0 = (cmd_ff.va != rc0) && (cmd_ff.va != rc1) && (cmd_ff.va != rc2);
   assign fresh1 = (cmd_ff.vb != rc0) && (cmd_ff.vb != rc1) && (cmd_ff.vb != rc2);
   assign fresh2 = (cmd_ff.vc != rc0) && (cmd_ff.vc != rc1) && (cmd_ff.vc != rc2);

   // right cell takes the face in reverse order
   assign reversed = state_ff == S_WR2;

   // one face absorbed into the cell just read
   always_comb begin
      ab_corners = corner_rd;
      ab_fill    = fill_rd;
      ab_we      = 1'b0;
      ab_st      = STAT_OK;
      case (fill_rd)
         FILL_EMPTY: begin
            ab_corners = reversed ? {rc3, cmd_ff.va, cmd_ff.vb, cmd_ff.vc}
                                  : {rc3, cmd_ff.vc, cmd_ff.vb, cmd_ff.va};
            ab_fill    = FILL_TRI;
            ab_we      = 1'b1;
         end
         FILL_TRI: begin
            ab_fill = FILL_FULL;
            ab_we   = 1'b1;
            if (fresh0) begin
               ab_corners = {cmd_ff.va, rc2, rc1, rc0};
            end else if (fresh1) begin
               ab_corners = {cmd_ff.vb, rc2, rc1, rc0};
            end else if (fresh2) begin
               ab_corners = {cmd_ff.vc, rc2, rc1, rc0};
            end else begin
               ab_fill = FILL_TRI;
               ab_we   = 1'b0;
               ab_st   = STAT_NOFOURTH;
            end
         end
         default: begin
            ab_we = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign face_p1  = (state_ff == S_P1) && (cmd_ff.op == OP_FACE);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      st_in     = st_ff;
      q_pop     = 1'b0;
      rsp_load  = 1'b0;
      load_data = '0;
      case (state_ff)
         S_IDLE: begin
            if (!clr_ff && q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               st_in    = q_head.range_err ? STAT_RANGE : STAT_OK;
               state_in = S_P1;
            end
         end
         S_P1: begin
            if (cmd_ff.op == OP_FACE) begin
               if (cmd_ff.do_left) begin
                  st_in = worse(st_ff, ab_st);
               end
               state_in = cmd_ff.do_right ? S_RD2 : S_DONE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               if (cmd_ff.op == OP_RDCELL) begin
                  load_data = {{PAD_W{1'b0}}, STAT_OK, {COUNT_W{1'b0}}, fill_rd, corner_rd};
               end else begin
                  load_data = {{PAD_W{1'b0}}, STAT_OK, mark_rd, {FILL_W{1'b0}},
                               {CORNERS_W{1'b0}}};
               end
               state_in = S_IDLE;
            end
         end
         S_RD2: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            st_in    = worse(st_ff, ab_st);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               load_data = {{PAD_W{1'b0}}, st_ff,
                            {(COUNT_W + FILL_W + CORNERS_W){1'b0}}};
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // clearing sweep after reset
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         if (clr_cnt_ff == CLR_AW'(CLR_COUNT - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_cnt_in = CLR_AW'(clr_cnt_ff + 1'b1);
         end
      end
   end

   assign clearing = clr_ff;

   // table addressing
   always_comb begin
      if (state_ff == S_IDLE) begin
         cell_ra = q_head.addr_a;
         mark_ra = q_head.mark_addr;
      end else if (state_ff == S_RD2) begin
         cell_ra = cmd_ff.addr_b;
         mark_ra = cmd_ff.mark_addr;
      end else begin
         cell_ra = cmd_ff.addr_a;
         mark_ra = cmd_ff.mark_addr;
      end
   end

   assign cell_wa = (state_ff == S_WR2) ? cmd_ff.addr_b : cmd_ff.addr_a;
   assign cell_we = !clr_ff && ab_we &&
                    ((face_p1 && cmd_ff.do_left) || (state_ff == S_WR2));

   assign fill_we = clr_ff ? (32'(clr_cnt_ff) < CELL_COUNT) : cell_we;
   assign fill_wa = clr_ff ? CELL_AW'(clr_cnt_ff) : cell_wa;
   assign fill_wd = clr_ff ? FILL_EMPTY : ab_fill;

   assign mark_we = clr_ff ? (32'(clr_cnt_ff) < MARKER_COUNT) : (face_p1 && cmd_ff.do_mark);
   assign mark_wa = clr_ff ? MARK_AW'(clr_cnt_ff) : cmd_ff.mark_addr;
   assign mark_wd = clr_ff ? '0 :
                    ((mark_rd == COUNT_MAX) ? mark_rd : COUNT_W'(mark_rd + 1'b1));

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         st_ff        <= STAT_OK;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (rsp_load) begin
         rsp_tdata_ff <= load_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   tcaf_ram #(
      .WIDTH (CORNERS_W),
      .DEPTH (CELL_COUNT)
   ) u_corner_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_wa),
      .wr_data (ab_corners),
      .rd_addr (cell_ra),
      .rd_data (corner_rd)
   );

   tcaf_ram #(
      .WIDTH (FILL_W),
      .DEPTH (CELL_COUNT)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_addr (cell_ra),
      .rd_data (fill_rd)
   );

   tcaf_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MARKER_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (mark_ra),
      .rd_data (mark_rd)
   );

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (!cell_we && !q_pop))
      else $error("table work during clearing sweep");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("pending result overwritten");

   a_pop_starts_phase_one: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_P1))
      else $error("popped command did not enter first phase");

   a_right_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR2) |-> ($past(state_ff) == S_RD2))
      else $error("right cell write without its read");

endmodule

### design/tet_cell_assembly_from_faces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_cell_assembly_from_faces
// builds tetrahedra from triangular faces and counts boundary markers
// ----------------------------------------------------------------------------
// usage
//   req channel carries one item per transfer: a face update, a cell read or
//   a marker count read, selected by req_tuser. rsp channel returns exactly
//   one result per item, in order.
//   the front end decodes and range checks each item and puts a command in a
//   two-entry queue; the back end runs the command against the cell corner,
//   cell fill and marker count rams, one table access sequence at a time.
// sequencing
//   a read passes the idle state and the first phase, where it loads the
//   result once the result register is free. a face passes the idle state,
//   the first phase and the done state, with the right cell read and
//   write-back states between the last two when it has a right cell.
// reset
//   after reset a clearing sweep over 4096 addresses zeroes the fill and marker
//   tables; req_tready stays low during it. corner contents are undefined
//   until a face writes them.
// stalls
//   a held rsp transfer parks the result register; the queue keeps taking
//   up to two items, then req_tready drops until the back end moves on.
// ----------------------------------------------------------------------------
module tet_cell_assembly_from_faces (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // vert_a[19:0], vert_b[39:20], vert_c[59:40], left_cell[72:60],
   // right_side[86:73], read_index[98:87], zero[103:99]
   input  logic [tcaf_pkg::REQ_W-1:0]    req_tdata,
   // kind[1:0]
   input  logic [tcaf_pkg::KIND_W-1:0]   req_tuser,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // corner_0[19:0], corner_1[39:20], corner_2[59:40], corner_3[79:60],
   // fill_level[81:80], marker_total[95:82], status[97:96], zero[103:98]
   output logic [tcaf_pkg::RSP_W-1:0]    rsp_tdata
);

   import tcaf_pkg::*;

   cmd_type   push_cmd;
   cmd_type   q_head;
   logic      push;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   logic      clearing;

   // decode and classify each transfer
   tcaf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decouples front and back so each side stalls on its own
   tcaf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // table sequencer and result register
   tcaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
